>>> sv/quaternion_to_euler_with_rates_core_assert.svh
// ----------------------------------------------------------------------------
// quaternion_to_euler_with_rates_core_assert.svh
// Assertion macros shared by the quaternion to euler core
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_WITH_RATES_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_WITH_RATES_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define QER_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must never hold
`define QER_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

>>> sv/qer_pkg.sv
// ----------------------------------------------------------------------------
// qer_pkg
// Shared widths, constants, types and helpers of the quaternion to euler core
// ----------------------------------------------------------------------------
package qer_pkg;

    // cordic stage count, limited by the arctangent table
    localparam int CORDIC_STAGES = 16;
    localparam int ARC_LEN       = 24;
    localparam int NS            = (CORDIC_STAGES > ARC_LEN) ? ARC_LEN : CORDIC_STAGES;

    // datapath widths
    localparam int PW   = 35;   // quaternion sums, 2^28 = 1.0
    localparam int SW   = 30;   // clamped asin argument
    localparam int RADW = 57;   // square root radicand
    localparam int SQB  = 29;   // square root result bits
    localparam int VW   = 38;   // vectoring cordic x and y
    localparam int RW   = 34;   // rotation cordic x and y, Q4.30
    localparam int QB   = 32;   // divider quotient bits
    localparam int DENW = RW - 1;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic signed [RW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [31:0]          ANG_PI   = 32'h8000_0000;

    // queued request after the front stages
    typedef struct packed {
        logic signed [PW-1:0] nr;
        logic signed [PW-1:0] dr;
        logic signed [PW-1:0] ny;
        logic signed [PW-1:0] dy;
        logic signed [SW-1:0] s;
        logic [RADW-1:0]      rad;
        logic signed [15:0]   p;
        logic signed [15:0]   q;
        logic signed [15:0]   r;
    } t_qitem;

    // finished result
    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] roll_dot;
        logic signed [15:0] pitch_dot;
        logic signed [15:0] yaw_dot;
        logic               sat;
    } t_result;

    typedef struct packed {
        logic               flag;
        logic signed [15:0] val;
    } t_sat;

    // arctangent of 2^-i, 2^31 = pi
    function automatic logic [31:0] arc_val(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd84998612;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // saturate to 16 bits signed
    function automatic t_sat sat16(input logic signed [31:0] v);
        t_sat s;
        s.flag = 1'b0;
        s.val  = v[15:0];
        if (v > 32'sd32767) begin
            s.flag = 1'b1;
            s.val  = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            s.flag = 1'b1;
            s.val  = 16'sh8000;
        end
        return s;
    endfunction

    // round a 32-bit angle to 16 bits, floor of (z + 2^15) / 2^16
    function automatic logic signed [16:0] angle16(input logic signed [31:0] z);
        logic signed [32:0] s;
        s = 33'(z) + 33'sd32768;
        return s[32:16];
    endfunction

endpackage

>>> sv/qer_front.sv
// ----------------------------------------------------------------------------
// qer_front
// Quaternion products, sums, asin clamp and square root radicand
// ----------------------------------------------------------------------------
module qer_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_gyro_p,
    input  logic signed [15:0] i_gyro_q,
    input  logic signed [15:0] i_gyro_r,
    input  logic               i_space,
    output logic               o_ready,
    output logic               o_push,
    output qer_pkg::t_qitem    o_item
);
    import qer_pkg::*;

    localparam logic signed [SW-1:0] S_MAX    = SW'(2**28);
    localparam logic [RADW-1:0]      RAD_TOP  = {1'b1, {(RADW-1){1'b0}}};

    logic en;
    logic r_v1, r_v2, r_v3;
    logic signed [31:0] r_ww, r_xx, r_yy, r_zz, r_wx, r_yz, r_wz, r_xy, r_wy, r_xz;
    logic signed [15:0] r_p1, r_q1, r_r1, r_p2, r_q2, r_r2;
    logic signed [PW-1:0] r_nr, r_dr, r_ny, r_dy;
    logic signed [SW-1:0] r_s;
    logic signed [PW-1:0] n_nr, n_dr, n_ny, n_dy, n_sraw;
    logic signed [SW-1:0] n_s;
    logic signed [2*SW-1:0] w_sq;
    t_qitem r_item;

    // the stages move unless the last one is held by a full queue
    assign en      = !r_v3 || i_space;
    assign o_ready = en;
    assign o_push  = r_v3 && i_space;
    assign o_item  = r_item;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1: component products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ww <= i_quat_w * i_quat_w;
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
            r_wx <= i_quat_w * i_quat_x;
            r_yz <= i_quat_y * i_quat_z;
            r_wz <= i_quat_w * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_wy <= i_quat_w * i_quat_y;
            r_xz <= i_quat_x * i_quat_z;
            r_p1 <= i_gyro_p;
            r_q1 <= i_gyro_q;
            r_r1 <= i_gyro_r;
        end
    end

    // stage 2 logic: atan2 operands and clamped asin argument
    always_comb begin
        n_nr   = (PW'(r_wx) + PW'(r_yz)) <<< 1;
        n_dr   = PW'(r_ww) - PW'(r_xx) - PW'(r_yy) + PW'(r_zz);
        n_ny   = (PW'(r_wz) + PW'(r_xy)) <<< 1;
        n_dy   = PW'(r_ww) + PW'(r_xx) - PW'(r_yy) - PW'(r_zz);
        n_sraw = (PW'(r_wy) - PW'(r_xz)) <<< 1;
        n_s    = n_sraw[SW-1:0];
        if (n_sraw > PW'(S_MAX)) begin
            n_s = S_MAX;
        end else if (n_sraw < -PW'(S_MAX)) begin
            n_s = -S_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nr <= n_nr;
            r_dr <= n_dr;
            r_ny <= n_ny;
            r_dy <= n_dy;
            r_s  <= n_s;
            r_p2 <= r_p1;
            r_q2 <= r_q1;
            r_r2 <= r_r1;
        end
    end

    // stage 3: radicand 1 - s^2 for the pitch cosine
    assign w_sq = r_s * r_s;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item.nr  <= r_nr;
            r_item.dr  <= r_dr;
            r_item.ny  <= r_ny;
            r_item.dy  <= r_dy;
            r_item.s   <= r_s;
            r_item.rad <= RAD_TOP - w_sq[RADW-1:0];
            r_item.p   <= r_p2;
            r_item.q   <= r_q2;
            r_item.r   <= r_r2;
        end
    end

endmodule

>>> sv/qer_queue.sv
// ----------------------------------------------------------------------------
// qer_queue
// Short request queue between the front and back pipelines
// ----------------------------------------------------------------------------
module qer_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qer_pkg::t_qitem i_item,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output qer_pkg::t_qitem o_item
);
    import qer_pkg::*;

    t_qitem r_mem [0:QDEPTH-1];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_item  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> sv/qer_vec_cordic.sv
// ----------------------------------------------------------------------------
// qer_vec_cordic
// Pipelined vectoring cordic, atan2(y, x) as a 32-bit angle, 2^31 = pi
// ----------------------------------------------------------------------------
module qer_vec_cordic (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [qer_pkg::VW-1:0] i_x,
    input  logic signed [qer_pkg::VW-1:0] i_y,
    output logic signed [31:0]         o_z
);
    import qer_pkg::*;

    logic signed [VW-1:0] r_x [0:NS];
    logic signed [VW-1:0] r_y [0:NS];
    logic [31:0]          r_z [0:NS];
    logic                 r_zero [0:NS];

    // fold the left half plane over and mark the zero vector
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= ANG_PI;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < NS; i++) begin : g_stage
        localparam logic [31:0] ARC = arc_val(i);
        logic signed [VW-1:0] w_dx, w_dy;
        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + w_dx;
                    r_y[i+1] <= r_y[i] - w_dy;
                    r_z[i+1] <= r_z[i] + ARC;
                end else begin
                    r_x[i+1] <= r_x[i] - w_dx;
                    r_y[i+1] <= r_y[i] + w_dy;
                    r_z[i+1] <= r_z[i] - ARC;
                end
            end
        end
    end

    assign o_z = r_zero[NS] ? 32'sd0 : $signed(r_z[NS]);

endmodule

>>> sv/qer_rot_cordic.sv
// ----------------------------------------------------------------------------
// qer_rot_cordic
// Pipelined rotation cordic, cosine and sine in Q4.30 of a 32-bit angle
// ----------------------------------------------------------------------------
module qer_rot_cordic (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [31:0]            i_z,
    output logic signed [qer_pkg::RW-1:0] o_cos,
    output logic signed [qer_pkg::RW-1:0] o_sin
);
    import qer_pkg::*;

    localparam logic signed [32:0] HALF_PI = 33'sd1073741824;
    localparam logic signed [32:0] PI_33   = 33'sd2147483648;

    logic signed [RW-1:0] r_x [0:NS];
    logic signed [RW-1:0] r_y [0:NS];
    logic signed [RW-1:0] r_z [0:NS];
    logic                 r_neg [0:NS];
    logic signed [32:0]   w_z;

    assign w_z = 33'(i_z);

    // bring the angle into the right half plane, remember the sign flip
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GAIN_Q30;
            r_y[0] <= '0;
            if (w_z > HALF_PI) begin
                r_z[0]   <= RW'(w_z - PI_33);
                r_neg[0] <= 1'b1;
            end else if (w_z < -HALF_PI) begin
                r_z[0]   <= RW'(w_z + PI_33);
                r_neg[0] <= 1'b1;
            end else begin
                r_z[0]   <= RW'(w_z);
                r_neg[0] <= 1'b0;
            end
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < NS; i++) begin : g_stage
        localparam logic signed [RW-1:0] ARC = $signed(RW'(arc_val(i)));
        logic signed [RW-1:0] w_dx, w_dy;
        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[i+1] <= r_neg[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - w_dx;
                    r_y[i+1] <= r_y[i] + w_dy;
                    r_z[i+1] <= r_z[i] - ARC;
                end else begin
                    r_x[i+1] <= r_x[i] + w_dx;
                    r_y[i+1] <= r_y[i] - w_dy;
                    r_z[i+1] <= r_z[i] + ARC;
                end
            end
        end
    end

    assign o_cos = r_neg[NS] ? -r_x[NS] : r_x[NS];
    assign o_sin = r_neg[NS] ? -r_y[NS] : r_y[NS];

endmodule

>>> sv/qer_back.sv
// ----------------------------------------------------------------------------
// qer_back
// Square root, angle cordics, rate products, divider and saturation
// ----------------------------------------------------------------------------
module qer_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  qer_pkg::t_qitem  i_item,
    input  logic             i_ready,
    output logic             o_pop,
    output logic             o_valid,
    output qer_pkg::t_result o_result
);
    import qer_pkg::*;

    localparam int TW       = 2 * SQB + 2;
    localparam int VEC_LAT  = NS + 1;
    localparam int ROT_LAT  = NS + 1;
    localparam int BACK_LAT = SQB + VEC_LAT + ROT_LAT + 3 + QB + 3;
    localparam int NUMW     = DENW + QB;

    typedef struct packed {
        logic signed [PW-1:0] nr;
        logic signed [PW-1:0] dr;
        logic signed [PW-1:0] ny;
        logic signed [PW-1:0] dy;
        logic signed [SW-1:0] s;
        logic signed [15:0]   p;
        logic signed [15:0]   q;
        logic signed [15:0]   r;
    } t_sqside;

    typedef struct packed {
        logic signed [15:0] p;
        logic signed [15:0] q;
        logic signed [15:0] r;
    } t_pqr;

    typedef struct packed {
        logic signed [15:0] p;
        logic signed [15:0] q;
        logic signed [15:0] r;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } t_rside;

    // carried through the divider
    typedef struct packed {
        logic                 tz;
        logic                 neg;
        logic                 ok;
        logic signed [50:0]   pr;
        logic signed [RW-1:0] sp;
        logic signed [15:0]   p;
        logic signed [15:0]   roll;
        logic signed [15:0]   pitch;
        logic signed [15:0]   yaw;
    } t_dside;

    logic en;
    logic r_vld [0:BACK_LAT-1];

    // whole back pipeline moves unless the output register is held
    assign en      = !r_vld[BACK_LAT-1] || i_ready;
    assign o_pop   = en && i_valid;
    assign o_valid = r_vld[BACK_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BACK_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < BACK_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic [RADW-1:0] r_rem  [0:SQB-1];
    logic [SQB-1:0]  r_root [0:SQB-1];
    t_sqside         r_sd   [0:SQB-1];

    for (genvar j = 0; j < SQB; j++) begin : g_sq
        localparam int K = SQB - 1 - j;
        logic [RADW-1:0] w_rem_in;
        logic [SQB-1:0]  w_root_in;
        t_sqside         w_sd_in;
        logic [TW-1:0]   w_trial;
        if (j == 0) begin : g_first
            assign w_rem_in  = i_item.rad;
            assign w_root_in = '0;
            assign w_sd_in   = '{nr: i_item.nr, dr: i_item.dr, ny: i_item.ny,
                                 dy: i_item.dy, s: i_item.s, p: i_item.p,
                                 q: i_item.q, r: i_item.r};
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_root_in = r_root[j-1];
            assign w_sd_in   = r_sd[j-1];
        end
        assign w_trial = (TW'(w_root_in) << (K + 1)) + (TW'(1) << (2 * K));
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sd[j] <= w_sd_in;
                if (TW'(w_rem_in) >= w_trial) begin
                    r_rem[j]  <= w_rem_in - w_trial[RADW-1:0];
                    r_root[j] <= w_root_in | (SQB'(1) << K);
                end else begin
                    r_rem[j]  <= w_rem_in;
                    r_root[j] <= w_root_in;
                end
            end
        end
    end

    // ---------------- vectoring cordics for the three angles ----------------
    t_sqside w_sq_out;
    logic signed [VW-1:0] w_px;
    logic signed [31:0] w_zr, w_zp, w_zy;
    t_pqr r_vs [0:VEC_LAT-1];

    assign w_sq_out = r_sd[SQB-1];
    assign w_px     = VW'(r_root[SQB-1]);

    qer_vec_cordic u_vec_roll (
        .i_clk (i_clk), .i_en (en),
        .i_x (VW'(w_sq_out.dr)), .i_y (VW'(w_sq_out.nr)), .o_z (w_zr)
    );
    qer_vec_cordic u_vec_pitch (
        .i_clk (i_clk), .i_en (en),
        .i_x (w_px), .i_y (VW'(w_sq_out.s)), .o_z (w_zp)
    );
    qer_vec_cordic u_vec_yaw (
        .i_clk (i_clk), .i_en (en),
        .i_x (VW'(w_sq_out.dy)), .i_y (VW'(w_sq_out.ny)), .o_z (w_zy)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vs[0] <= '{p: w_sq_out.p, q: w_sq_out.q, r: w_sq_out.r};
            for (int i = 1; i < VEC_LAT; i++) begin
                r_vs[i] <= r_vs[i-1];
            end
        end
    end

    // ---------------- rounded angles and rotation cordics ----------------
    logic signed [16:0] w_pa, w_ra, w_ya;
    logic signed [15:0] w_pitch16;
    t_rside w_rs_in;
    t_rside r_rs [0:ROT_LAT-1];
    logic signed [RW-1:0] w_cx, w_sx, w_cp, w_sp;

    always_comb begin
        w_ra      = angle16(w_zr);
        w_ya      = angle16(w_zy);
        w_pa      = angle16(w_zp);
        w_pitch16 = w_pa[15:0];
        if (w_pa > 17'sd16384) begin
            w_pitch16 = 16'sd16384;
        end else if (w_pa < -17'sd16384) begin
            w_pitch16 = -16'sd16384;
        end
    end

    assign w_rs_in = '{p: r_vs[VEC_LAT-1].p, q: r_vs[VEC_LAT-1].q,
                       r: r_vs[VEC_LAT-1].r, roll: w_ra[15:0],
                       pitch: w_pitch16, yaw: w_ya[15:0]};

    qer_rot_cordic u_rot_roll (
        .i_clk (i_clk), .i_en (en), .i_z (w_zr), .o_cos (w_cx), .o_sin (w_sx)
    );
    qer_rot_cordic u_rot_pitch (
        .i_clk (i_clk), .i_en (en), .i_z (w_zp), .o_cos (w_cp), .o_sin (w_sp)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rs[0] <= w_rs_in;
            for (int i = 1; i < ROT_LAT; i++) begin
                r_rs[i] <= r_rs[i-1];
            end
        end
    end

    // ---------------- rate products ----------------
    t_rside w_rs;
    logic signed [49:0] r1_sq, r1_cr, r1_cq, r1_sr;
    logic signed [RW-1:0] r1_cp, r1_sp;
    t_rside r1_rs;

    assign w_rs = r_rs[ROT_LAT-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sq <= w_sx * w_rs.q;
            r1_cr <= w_cx * w_rs.r;
            r1_cq <= w_cx * w_rs.q;
            r1_sr <= w_sx * w_rs.r;
            r1_cp <= w_cp;
            r1_sp <= w_sp;
            r1_rs <= w_rs;
        end
    end

    // ---------------- t, pitch rate numerator, range check ----------------
    logic signed [50:0] w_t, w_pr;
    logic [50:0] w_mag;
    logic w_ok;
    logic [50:0] r2_mag;
    logic r2_ok, r2_tz, r2_neg;
    logic signed [50:0] r2_pr;
    logic signed [RW-1:0] r2_cp, r2_sp;
    t_rside r2_rs;

    always_comb begin
        w_t   = 51'(r1_sq) + 51'(r1_cr);
        w_pr  = 51'(r1_cq) - 51'(r1_sr);
        w_mag = w_t[50] ? 51'(-w_t) : 51'(w_t);
        w_ok  = (r1_cp > 0) && (52'(w_mag) < (52'(r1_cp[DENW-1:0]) << 17));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_mag <= w_mag;
            r2_ok  <= w_ok;
            r2_tz  <= (w_t == '0);
            r2_neg <= w_t[50];
            r2_pr  <= w_pr;
            r2_cp  <= r1_cp;
            r2_sp  <= r1_sp;
            r2_rs  <= r1_rs;
        end
    end

    // ---------------- rounded dividend ----------------
    logic [NUMW-1:0] w_num;
    logic [DENW-1:0] r3_rem, r3_den;
    logic [QB-1:0]   r3_nlo;
    t_dside          r3_sd;

    assign w_num = r2_ok ? ((NUMW'(r2_mag) << 14) + NUMW'(r2_cp[DENW-1:1])) : '0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_rem <= w_num[NUMW-1:QB];
            r3_nlo <= w_num[QB-1:0];
            r3_den <= r2_cp[DENW-1:0];
            r3_sd  <= '{tz: r2_tz, neg: r2_neg, ok: r2_ok, pr: r2_pr, sp: r2_sp,
                        p: r2_rs.p, roll: r2_rs.roll, pitch: r2_rs.pitch,
                        yaw: r2_rs.yaw};
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    logic [DENW-1:0] r_drem [0:QB-1];
    logic [DENW-1:0] r_dden [0:QB-1];
    logic [QB-1:0]   r_dnlo [0:QB-1];
    logic [QB-1:0]   r_dquo [0:QB-1];
    t_dside          r_dsd  [0:QB-1];

    for (genvar d = 0; d < QB; d++) begin : g_div
        localparam int B = QB - 1 - d;
        logic [DENW-1:0] w_rem_in, w_den_in;
        logic [QB-1:0]   w_nlo_in, w_quo_in;
        t_dside          w_sd_in;
        logic [DENW:0]   w_sh;
        if (d == 0) begin : g_first
            assign w_rem_in = r3_rem;
            assign w_den_in = r3_den;
            assign w_nlo_in = r3_nlo;
            assign w_quo_in = '0;
            assign w_sd_in  = r3_sd;
        end else begin : g_next
            assign w_rem_in = r_drem[d-1];
            assign w_den_in = r_dden[d-1];
            assign w_nlo_in = r_dnlo[d-1];
            assign w_quo_in = r_dquo[d-1];
            assign w_sd_in  = r_dsd[d-1];
        end
        assign w_sh = {w_rem_in, w_nlo_in[B]};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dden[d] <= w_den_in;
                r_dnlo[d] <= w_nlo_in;
                r_dsd[d]  <= w_sd_in;
                if (w_sh >= {1'b0, w_den_in}) begin
                    r_drem[d] <= DENW'(w_sh - {1'b0, w_den_in});
                    r_dquo[d] <= w_quo_in | (QB'(1) << B);
                end else begin
                    r_drem[d] <= w_sh[DENW-1:0];
                    r_dquo[d] <= w_quo_in;
                end
            end
        end
    end

    // ---------------- u = t / cos(pitch), Q.14 ----------------
    t_dside w_dsd;
    logic [QB-1:0] w_quo;
    logic signed [QB:0] w_u;
    logic signed [QB:0] r4_u;
    logic r4_flag;
    t_dside r4_sd;

    localparam logic signed [QB:0] U_SAT = {2'b01, {(QB-1){1'b0}}};

    assign w_dsd = r_dsd[QB-1];
    assign w_quo = r_dquo[QB-1];

    always_comb begin
        if (w_dsd.tz) begin
            w_u = '0;
        end else if (!w_dsd.ok) begin
            w_u = w_dsd.neg ? -U_SAT : U_SAT;
        end else begin
            w_u = w_dsd.neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_u    <= w_u;
            r4_flag <= !w_dsd.tz && !w_dsd.ok;
            r4_sd   <= w_dsd;
        end
    end

    // ---------------- sin(pitch) * u, yaw and pitch rates ----------------
    logic signed [QB+1:0] w_yr;
    logic signed [51:0]   w_pn;
    t_sat w_ysat, w_psat;
    logic signed [RW+QB:0] r5_prod;
    logic signed [15:0] r5_yr, r5_prr;
    logic r5_flag;
    t_dside r5_sd;

    always_comb begin
        w_yr   = ((QB+2)'(r4_u) + (QB+2)'(8192)) >>> 14;
        w_pn   = (52'(r4_sd.pr) + 52'sd536870912) >>> 30;
        w_ysat = sat16(32'(w_yr));
        w_psat = sat16(32'(w_pn));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_prod <= r4_sd.sp * r4_u;
            r5_yr   <= w_ysat.val;
            r5_prr  <= w_psat.val;
            r5_flag <= r4_flag || w_ysat.flag || w_psat.flag;
            r5_sd   <= r4_sd;
        end
    end

    // ---------------- roll rate and output register ----------------
    logic signed [RW+QB+1:0] w_rsum;
    logic signed [24:0] w_rr;
    t_sat w_rsat;
    t_result r_out;

    always_comb begin
        w_rsum = ((RW+QB+2)'(r5_prod) + (RW+QB+2)'(64'sd8796093022208)) >>> 44;
        w_rr   = 25'(r5_sd.p) + 25'(w_rsum);
        w_rsat = sat16(32'(w_rr));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.roll      <= r5_sd.roll;
            r_out.pitch     <= r5_sd.pitch;
            r_out.yaw       <= r5_sd.yaw;
            r_out.roll_dot  <= w_rsat.val;
            r_out.pitch_dot <= r5_prr;
            r_out.yaw_dot   <= r5_yr;
            r_out.sat       <= r5_flag || w_rsat.flag;
        end
    end

    assign o_result = r_out;

endmodule

>>> sv/quaternion_to_euler_with_rates_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_with_rates_core
// Quaternion to yaw-pitch-roll angles and body to euler rate conversion
// ----------------------------------------------------------------------------
// Takes one sample per cycle unless stalled and returns one result per
// sample, in order. A sample passes three front stages, a four-entry
// queue, then the back pipeline: 29 square root stages, two cordic passes
// of CORDIC_STAGES+1 stages each, 3 product stages, 32 divider stages and
// 3 output stages. The fully pipelined square root, cordic and divider
// chains set the rate of one sample per clock; a held output stalls the
// back pipeline, and the queue lets the front keep taking samples until
// it fills.
module quaternion_to_euler_with_rates_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, gyro_p, gyro_q, gyro_r (16 bits each)
    input  logic [111:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // roll_angle, pitch_angle, yaw_angle, roll_dot, pitch_dot, yaw_dot
    output logic [95:0]  o_m_axis_tdata,
    // rate_saturated
    output logic         o_m_axis_tuser
);
    import qer_pkg::*;

    `include "quaternion_to_euler_with_rates_core_assert.svh"

    logic   w_push, w_pop, w_q_valid, w_q_full;
    logic   w_pitch_ok;
    t_qitem w_push_item, w_q_item;
    t_result w_res;

    // request front end
    qer_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_quat_x (i_s_axis_tdata[15:0]),
        .i_quat_y (i_s_axis_tdata[31:16]),
        .i_quat_z (i_s_axis_tdata[47:32]),
        .i_quat_w (i_s_axis_tdata[63:48]),
        .i_gyro_p (i_s_axis_tdata[79:64]),
        .i_gyro_q (i_s_axis_tdata[95:80]),
        .i_gyro_r (i_s_axis_tdata[111:96]),
        .i_space  (!w_q_full),
        .o_ready  (o_s_axis_tready),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    // decoupling queue
    qer_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_item  (w_q_item)
    );

    // trig, division and rate back end
    qer_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_item   (w_q_item),
        .i_ready  (i_m_axis_tready),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .o_result (w_res)
    );

    // result packing
    assign o_m_axis_tdata = {w_res.yaw_dot, w_res.pitch_dot, w_res.roll_dot,
                             w_res.yaw, w_res.pitch, w_res.roll};
    assign o_m_axis_tuser = w_res.sat;

    // pitch stays within plus and minus ninety degrees
    assign w_pitch_ok = (w_res.pitch <= 16'sd16384) && (w_res.pitch >= -16'sd16384);

    // checks
    `QER_ASSERT_NEVER(a_queue_overflow, w_push && w_q_full, "queue push while full")
    `QER_ASSERT_IMPLY(a_pop_nonempty, w_pop, w_q_valid, "queue pop while empty")
    `QER_ASSERT_IMPLY(a_pitch_range, o_m_axis_tvalid, w_pitch_ok, "pitch out of range")

endmodule
